// File: hdl/vc2argb_pkg.sv
`default_nettype none

package vc2argb_pkg;

  typedef enum logic [2:0] {
    FMT_RGB565   = 3'd0,
    FMT_RGB888   = 3'd1,
    FMT_RGB888X  = 3'd2,
    FMT_RGBA4444 = 3'd3,
    FMT_RGBA6666 = 3'd4,
    FMT_RGBA8888 = 3'd5
  } fmt_e;

  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;
  localparam logic [2:0] NEED_NONE    = 3'd0;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  function automatic logic [2:0] bytes_needed(input logic [2:0] fmt);
    logic [2:0] n;
    n = NEED_NONE;
    case (fmt)
      FMT_RGB565, FMT_RGBA4444:  n = 3'd2;
      FMT_RGB888, FMT_RGBA6666:  n = 3'd3;
      FMT_RGB888X, FMT_RGBA8888: n = 3'd4;
      default:                   n = NEED_NONE;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

`default_nettype wire

// File: hdl/vertex_color_to_argb8888_unit.sv
// The result is registered and valid in the cycle after the transaction of the byte that completes a color.
// Throughput: one byte per cycle while not stalled; a byte can be taken in the cycle the held result is taken.
// The output register stalls the input only while it holds a result that is stalled.
// Reset (rst_ni low, asynchronous): format rgb565, no bytes held, no result pending.
`default_nettype none

module vertex_color_to_argb8888_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic [7:0]       alpha_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i
);

  logic [2:0]         fmt_q;
  logic [1:0]         cnt_q, cnt_d;
  logic [23:0]        held_q, held_d;
  logic               out_valid_q;
  vc2argb_pkg::argb_t res_q, res_d;

  logic        cfg_wr;
  logic        in_acc;
  logic [2:0]  need;
  logic [2:0]  cnt_inc;
  logic        complete;
  logic [31:0] word;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {29'd0, fmt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= vc2argb_pkg::FMT_RGB565;
    end else if (cfg_wr) begin
      fmt_q <= pwdata[2:0];
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign need       = vc2argb_pkg::bytes_needed(fmt_q);
  assign cnt_inc    = {1'b0, cnt_q} + 3'd1;
  assign complete   = (need != vc2argb_pkg::NEED_NONE) && (cnt_inc >= need);
  assign word       = {held_q, data_byte_i};

  always_comb begin
    cnt_d  = cnt_q;
    held_d = held_q;
    if (in_acc && need != vc2argb_pkg::NEED_NONE) begin
      if (complete) begin
        cnt_d  = 2'd0;
        held_d = 24'd0;
      end else begin
        cnt_d  = cnt_inc[1:0];
        held_d = word[23:0];
      end
    end
  end

  always_comb begin
    res_d = '0;
    unique case (vc2argb_pkg::fmt_e'(fmt_q))
      vc2argb_pkg::FMT_RGB565: begin
        res_d.alpha = vc2argb_pkg::OPAQUE_ALPHA;
        res_d.red   = vc2argb_pkg::widen5(word[15:11]);
        res_d.green = vc2argb_pkg::widen6(word[10:5]);
        res_d.blue  = vc2argb_pkg::widen5(word[4:0]);
      end
      vc2argb_pkg::FMT_RGB888: begin
        res_d.alpha = vc2argb_pkg::OPAQUE_ALPHA;
        res_d.red   = word[23:16];
        res_d.green = word[15:8];
        res_d.blue  = word[7:0];
      end
      vc2argb_pkg::FMT_RGB888X: begin
        res_d.alpha = vc2argb_pkg::OPAQUE_ALPHA;
        res_d.red   = word[31:24];
        res_d.green = word[23:16];
        res_d.blue  = word[15:8];
      end
      vc2argb_pkg::FMT_RGBA4444: begin
        res_d.red   = vc2argb_pkg::widen4(word[15:12]);
        res_d.green = vc2argb_pkg::widen4(word[11:8]);
        res_d.blue  = vc2argb_pkg::widen4(word[7:4]);
        res_d.alpha = vc2argb_pkg::widen4(word[3:0]);
      end
      vc2argb_pkg::FMT_RGBA6666: begin
        res_d.red   = vc2argb_pkg::widen6(word[23:18]);
        res_d.green = vc2argb_pkg::widen6(word[17:12]);
        res_d.blue  = vc2argb_pkg::widen6(word[11:6]);
        res_d.alpha = vc2argb_pkg::widen6(word[5:0]);
      end
      vc2argb_pkg::FMT_RGBA8888: begin
        res_d.red   = word[31:24];
        res_d.green = word[23:16];
        res_d.blue  = word[15:8];
        res_d.alpha = word[7:0];
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 2'd0;
      held_q      <= 24'd0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
      if (in_acc && complete) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && complete) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alpha_o     = res_q.alpha;
  assign red_o       = res_q.red;
  assign green_o     = res_q.green;
  assign blue_o      = res_q.blue;

endmodule

`default_nettype wire

// File: hdl/vc2argb_checker.sv
`default_nettype none

module vc2argb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] alpha_o,
  input wire logic [7:0] red_o,
  input wire logic [7:0] green_o,
  input wire logic [7:0] blue_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_new_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !($past(out_valid_o) && $past(out_stall_i)) |-> $past(in_acc))
    else $error("result without a transaction on the input");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(alpha_o) && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed");

endmodule

bind vertex_color_to_argb8888_unit vc2argb_checker u_vc2argb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .alpha_o     (alpha_o),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
